// ===== hdl/ffd_pkg.sv =====
`default_nettype none

package ffd_pkg;

	typedef logic [1:0] reg_idx_t;

	localparam reg_idx_t REG_DELAY_TARGET  = 2'd0;
	localparam reg_idx_t REG_FEEDBACK_GAIN = 2'd1;
	localparam reg_idx_t REG_BUFFER_LENGTH = 2'd2;

	localparam int          DELAY_W     = 24;
	localparam logic [23:0] DELAY_RESET = 24'd256;

	typedef struct packed {
		logic load;
		logic step;
	} ramp_ctl_t;

	function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
		logic signed [15:0] r;
		if (v > 18'sd32767) begin
			r = 16'sh7fff;
		end else if (v < -18'sd32768) begin
			r = -16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/ffd_store.sv =====
`default_nettype none

module ffd_store #(
	parameter  int DEPTH  = 65536,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [ADDR_W-1:0]        waddr,
	input  wire logic signed [15:0]       wdata,
	input  wire logic                     re,
	input  wire logic [ADDR_W-1:0]        raddr0,
	input  wire logic [ADDR_W-1:0]        raddr1,
	output      logic signed [15:0]       rdata0,
	output      logic signed [15:0]       rdata1
);

	logic signed [15:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata0 <= mem[raddr0];
			rdata1 <= mem[raddr1];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/ffd_ramp.sv =====
`default_nettype none

module ffd_ramp #(
	parameter int RAMP_STEPS = 1024
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire ffd_pkg::ramp_ctl_t   ctl,
	input  wire logic [23:0]          delay_target,
	output      logic [23:0]          cur_delay
);
	import ffd_pkg::*;

	localparam int          RW          = $clog2(RAMP_STEPS + 1);
	localparam int          RECIP_SHIFT = DELAY_W + $clog2(RAMP_STEPS);
	localparam logic [63:0] RECIP_FULL  =
		((64'd1 << RECIP_SHIFT) + 64'(RAMP_STEPS) - 64'd1) / 64'(RAMP_STEPS);
	localparam logic [25:0] RECIP       = RECIP_FULL[25:0];

	logic [23:0]        seen_q;
	logic [23:0]        cur_q;
	logic signed [24:0] inc_q;
	logic [RW-1:0]      rem_q;

	logic               chg_s1;
	logic               neg_s1;
	logic [49:0]        prod_s1;

	logic signed [24:0] diff;
	logic [24:0]        diff_abs;
	logic [23:0]        quot;
	logic signed [24:0] inc_new;
	logic signed [24:0] inc_eff;
	logic [RW-1:0]      rem_eff;
	logic [RW-1:0]      rem_dec;
	logic signed [24:0] cur_sum;

	assign diff     = $signed({1'b0, delay_target}) - $signed({1'b0, cur_q});
	assign diff_abs = diff[24] ? 25'(-diff) : 25'(diff);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			chg_s1  <= (delay_target != seen_q);
			neg_s1  <= diff[24];
			prod_s1 <= diff_abs[23:0] * RECIP;
		end
	end

	assign quot    = 24'(prod_s1 >> RECIP_SHIFT);
	assign inc_new = neg_s1 ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
	assign inc_eff = chg_s1 ? inc_new : inc_q;
	assign rem_eff = chg_s1 ? RW'(RAMP_STEPS) : rem_q;
	assign rem_dec = rem_eff - RW'(1);
	assign cur_sum = $signed({1'b0, cur_q}) + inc_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= DELAY_RESET;
			cur_q  <= DELAY_RESET;
			inc_q  <= '0;
			rem_q  <= '0;
		end else if (ctl.step) begin
			if (chg_s1) begin
				seen_q <= delay_target;
				inc_q  <= inc_new;
			end
			if (rem_eff != '0) begin
				rem_q <= rem_dec;
				if (rem_dec != '0) begin
					cur_q <= cur_sum[23:0];
				end else begin
					cur_q <= chg_s1 ? delay_target : seen_q;
				end
			end else begin
				rem_q <= rem_eff;
			end
		end
	end

	assign cur_delay = cur_q;

endmodule

`default_nettype wire

// ===== hdl/feedback_fractional_delay_core.sv =====
// An input beat is buffered, then passes the feedback, write, read-address and
// interpolate states; ST_MAC registers the output beat and waits on out_stall.
// One sample at a time uses the single sample store (the next needs this output).
// Reset: control, ramp and config state clear; the store is not swept, a fill
// count makes never-written entries read as zero, so no clearing pass is needed.
`default_nettype none

module feedback_fractional_delay_core #(
	parameter int MAX_SAMPLES = 65536,
	parameter int RAMP_STEPS  = 1024
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output      logic               in_stall,
	input  wire logic signed [15:0] in_sample,
	input  wire logic               block_end_in,
	output      logic               out_valid,
	input  wire logic               out_stall,
	output      logic signed [15:0] out_sample,
	output      logic               block_end_out,
	input  wire logic               cfg_valid,
	output      logic               cfg_ready,
	input  wire ffd_pkg::reg_idx_t  cfg_index,
	input  wire logic [23:0]        cfg_data
);
	import ffd_pkg::*;

	localparam int AW      = $clog2(MAX_SAMPLES);
	localparam int LW      = $clog2(MAX_SAMPLES + 1);
	localparam int CW      = (LW > 17) ? LW : 17;
	localparam int EW      = (LW + 8 > 24) ? LW + 8 : 24;
	localparam int PW      = LW + 9;
	localparam int LEN_RST = (MAX_SAMPLES < 65536) ? MAX_SAMPLES : 65536;

	typedef enum logic [1:0] {ST_FB, ST_WR, ST_AD, ST_MAC} state_t;

	state_t             state_q;
	logic               buf_valid_q;
	logic signed [15:0] buf_sample_q;
	logic               buf_end_q;
	logic               out_valid_q;
	logic signed [15:0] out_sample_q;
	logic               out_end_q;

	logic [23:0]        target_q;
	logic [14:0]        gain_q;
	logic [LW-1:0]      len_q;
	logic [AW-1:0]      wp_q;
	logic [LW-1:0]      fill_q;
	logic signed [15:0] prev_q;

	logic [AW-1:0]      wpw_s1;
	logic signed [31:0] fbp_s1;
	logic signed [15:0] x_s1;
	logic               end_s1;
	logic               end_s2;
	logic [7:0]         frac_s3;
	logic               v0_s3;
	logic               v1_s3;
	logic               end_s3;

	ramp_ctl_t          ramp_ctl;
	logic [23:0]        cur_delay;

	logic [CW-1:0]      len_ext;
	logic [LW-1:0]      len_new;

	logic signed [31:0] fb_round;
	logic signed [16:0] fb17;
	logic signed [17:0] wsum;
	logic signed [15:0] wdata;
	logic [LW-1:0]      wp_inc;

	logic [EW-1:0]      d_ext;
	logic [EW-1:0]      hi_ext;
	logic [EW-1:0]      dcl;
	logic signed [PW-1:0] pos_raw;
	logic signed [PW-1:0] pos;
	logic [AW-1:0]      x0;
	logic [LW-1:0]      x1_inc;
	logic [AW-1:0]      x1;
	logic               rd_en;

	logic signed [15:0] rd0;
	logic signed [15:0] rd1;
	logic signed [15:0] y0;
	logic signed [15:0] y1;
	logic signed [16:0] dy;
	logic signed [25:0] mac;
	logic signed [25:0] acc;
	logic signed [15:0] res;
	logic               out_free;

	assign cfg_ready = 1'b1;
	assign in_stall  = buf_valid_q;
	assign out_valid = out_valid_q;
	assign out_sample    = out_sample_q;
	assign block_end_out = out_end_q;
	assign out_free  = !out_valid_q || !out_stall;

	assign len_ext = CW'(cfg_data[16:0]);
	always_comb begin
		if (len_ext < CW'(2)) begin
			len_new = LW'(2);
		end else if (len_ext > CW'(MAX_SAMPLES)) begin
			len_new = LW'(MAX_SAMPLES);
		end else begin
			len_new = len_ext[LW-1:0];
		end
	end

	// feedback and write path
	assign fb_round = fbp_s1 + 32'sd16384;
	assign fb17     = fb_round[31:15];
	assign wsum     = {{2{x_s1[15]}}, x_s1} + {fb17[16], fb17};
	assign wdata    = sat16(wsum);
	assign wp_inc   = LW'(wpw_s1) + LW'(1);

	// read address: write position minus clamped delay, wrapped
	assign d_ext  = EW'(cur_delay);
	assign hi_ext = EW'({len_q - LW'(1), 8'h00});
	always_comb begin
		if (d_ext < EW'(256)) begin
			dcl = EW'(256);
		end else if (d_ext > hi_ext) begin
			dcl = hi_ext;
		end else begin
			dcl = d_ext;
		end
	end
	assign pos_raw = $signed({1'b0, LW'(wp_q), 8'h00}) - $signed({1'b0, dcl[LW+7:0]});
	assign pos     = pos_raw[PW-1] ? pos_raw + $signed({1'b0, len_q, 8'h00}) : pos_raw;
	assign x0      = pos[AW+7:8];
	assign x1_inc  = LW'(x0) + LW'(1);
	assign x1      = (x1_inc >= len_q) ? '0 : x1_inc[AW-1:0];
	assign rd_en   = (state_q == ST_AD);

	// interpolation: y0 + f*(y1-y0)/256, rounded
	assign y0  = v0_s3 ? rd0 : 16'sd0;
	assign y1  = v1_s3 ? rd1 : 16'sd0;
	assign dy  = {y1[15], y1} - {y0[15], y0};
	assign mac = dy * $signed({1'b0, frac_s3});
	assign acc = $signed({{2{y0[15]}}, y0, 8'h00}) + mac + 26'sd128;
	assign res = sat16(acc[25:8]);

	assign ramp_ctl.load = (state_q == ST_FB) && buf_valid_q;
	assign ramp_ctl.step = (state_q == ST_WR);

	ffd_ramp #(
		.RAMP_STEPS(RAMP_STEPS)
	) u_ramp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ramp_ctl),
		.delay_target(target_q),
		.cur_delay   (cur_delay)
	);

	ffd_store #(
		.DEPTH(MAX_SAMPLES)
	) u_store (
		.clk   (clk),
		.we    (state_q == ST_WR),
		.waddr (wpw_s1),
		.wdata (wdata),
		.re    (rd_en),
		.raddr0(x0),
		.raddr1(x1),
		.rdata0(rd0),
		.rdata1(rd1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_FB;
			buf_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
			target_q    <= DELAY_RESET;
			gain_q      <= '0;
			len_q       <= LW'(LEN_RST);
			wp_q        <= '0;
			fill_q      <= '0;
			prev_q      <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_DELAY_TARGET:  target_q <= cfg_data;
					REG_FEEDBACK_GAIN: gain_q   <= cfg_data[14:0];
					REG_BUFFER_LENGTH: len_q    <= len_new;
					default: ;
				endcase
			end
			if (state_q == ST_MAC && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (in_valid && !in_stall) begin
				buf_valid_q <= 1'b1;
			end
			case (state_q)
				ST_FB: begin
					if (buf_valid_q) begin
						buf_valid_q <= 1'b0;
						state_q     <= ST_WR;
					end
				end
				ST_WR: begin
					wp_q <= (wp_inc >= len_q) ? '0 : wp_inc[AW-1:0];
					if (LW'(wpw_s1) == fill_q) begin
						fill_q <= fill_q + LW'(1);
					end
					state_q <= ST_AD;
				end
				ST_AD: begin
					state_q <= ST_MAC;
				end
				ST_MAC: begin
					if (out_free) begin
						prev_q  <= res;
						state_q <= ST_FB;
					end
				end
				default: state_q <= ST_FB;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			buf_sample_q <= in_sample;
			buf_end_q    <= block_end_in;
		end
		if (state_q == ST_FB && buf_valid_q) begin
			wpw_s1 <= (LW'(wp_q) >= len_q) ? '0 : wp_q;
			fbp_s1 <= $signed({1'b0, gain_q}) * prev_q;
			x_s1   <= buf_sample_q;
			end_s1 <= buf_end_q;
		end
		if (state_q == ST_WR) begin
			end_s2 <= end_s1;
		end
		if (state_q == ST_AD) begin
			frac_s3 <= pos[7:0];
			v0_s3   <= LW'(x0) < fill_q;
			v1_s3   <= LW'(x1) < fill_q;
			end_s3  <= end_s2;
		end
		if (state_q == ST_MAC && out_free) begin
			out_sample_q <= res;
			out_end_q    <= end_s3;
		end
	end

`ifndef ASSERT_OFF
	a_out_from_mac: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_MAC))
		else $error("output beat raised outside interpolate step");

	a_fill_covers_wp: assert property (@(posedge clk) disable iff (!arst_n)
		LW'(wp_q) <= fill_q)
		else $error("write position ahead of fill count");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WR) |-> (LW'(wpw_s1) < len_q))
		else $error("store write beyond active length");

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_AD) |-> (LW'(x0) < len_q && LW'(x1) < len_q))
		else $error("store read beyond active length");
`endif

endmodule

`default_nettype wire
